// File: sv/bsp_pkg.sv
// Shared types and constants for the rectangle packer.
`default_nettype none
package bsp_pkg;
	localparam int MaxNodes   = 1024;
	localparam int CoordBits  = 13;
	localparam int IdxBits    = $clog2(MaxNodes);
	localparam int CntBits    = $clog2(MaxNodes + 1);
	localparam int LinkBits   = 16;
	localparam logic [LinkBits-1:0] LinkFull  = 16'hFFFF;
	localparam logic [LinkBits-1:0] LinkEmpty = 16'hFFFE;
	localparam logic SplitTb = 1'b0;
	localparam logic SplitLr = 1'b1;
	localparam logic [1:0] StPlaced = 2'd0;
	localparam logic [1:0] StNoFit  = 2'd1;
	localparam logic [1:0] StFull   = 2'd2;
	localparam logic CfgWidth  = 1'b0;
	localparam logic CfgHeight = 1'b1;

	typedef logic [CoordBits-1:0] coord_t;

	typedef struct packed {
		logic                kind;
		coord_t              split;
		logic [LinkBits-1:0] link_a;
		logic [LinkBits-1:0] link_b;
	} node_t;

	typedef struct packed {
		coord_t             x;
		coord_t             y;
		coord_t             w;
		coord_t             h;
		logic [IdxBits-1:0] node;
		logic               tried_a;
	} entry_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CLEAR, ST_START, ST_RDSTK, ST_RDNODE, ST_EVAL,
		ST_INS1, ST_INS2, ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic clear;
		logic start;
		logic rd_stack;
		logic rd_node;
		logic eval;
		logic ins1;
		logic ins2;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clear_done;
		logic stack_empty;
		logic drop;
		logic finish;
		logic no_room;
		logic need1;
		logic need2;
	} sts_t;
endpackage
`default_nettype wire

// File: sv/bsp_if.sv
// Valid/ready channel interfaces for requests and results.
`default_nettype none
interface bsp_req_if;
	logic                   valid;
	logic                   ready;
	bsp_pkg::coord_t        req_width;
	bsp_pkg::coord_t        req_height;
	modport source (output valid, req_width, req_height, input ready);
	modport sink   (input valid, req_width, req_height, output ready);
endinterface

interface bsp_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [11:0] pos_x;
	logic [11:0] pos_y;
	modport source (output valid, status, pos_x, pos_y, input ready);
	modport sink   (input valid, status, pos_x, pos_y, output ready);
endinterface
`default_nettype wire

// File: sv/bsp_datapath.sv
// Datapath: node and stack memories, region arithmetic and insertion.
`default_nettype none
module bsp_datapath (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire bsp_pkg::cmd_t cmd,
	output bsp_pkg::sts_t      sts,
	input  wire logic          cfg_we,
	input  wire logic          cfg_sel,
	input  wire bsp_pkg::coord_t cfg_val,
	input  wire bsp_pkg::coord_t rw,
	input  wire bsp_pkg::coord_t rh,
	output logic [1:0]         res_status,
	output logic [11:0]        res_x,
	output logic [11:0]        res_y
);
	localparam int IB = bsp_pkg::IdxBits;
	localparam int CB = bsp_pkg::CntBits;

	bsp_pkg::node_t  node_mem [bsp_pkg::MaxNodes];
	bsp_pkg::entry_t stk_mem  [bsp_pkg::MaxNodes];

	bsp_pkg::coord_t aw_q, ah_q;
	logic [CB-1:0]   count_q, depth_q, clr_q;
	bsp_pkg::entry_t ent_q;
	bsp_pkg::node_t  node_q;
	// request size held for the whole walk
	bsp_pkg::coord_t rw_q, rh_q;
	// evaluation results kept for insertion
	logic [IB-1:0]   tn_q;
	logic            side_q, need_w_q, need_h_q;

	// Derived region for the side being tried
	bsp_pkg::coord_t ex, ey, ew, eh;
	logic            side;
	logic [15:0]     link;
	always_comb begin
		ex = ent_q.x; ey = ent_q.y; ew = ent_q.w; eh = ent_q.h;
		side = ent_q.tried_a;
		if (node_q.kind == bsp_pkg::SplitTb) begin
			if (side) begin
				ey = ent_q.y + node_q.split;
				eh = (ent_q.h >= node_q.split) ? ent_q.h - node_q.split : '0;
			end else eh = node_q.split;
		end else begin
			if (side) begin
				ex = ent_q.x + node_q.split;
				ew = (ent_q.w >= node_q.split) ? ent_q.w - node_q.split : '0;
			end else ew = node_q.split;
		end
		link = side ? node_q.link_b : node_q.link_a;
	end

	logic fits, nw, nh, room;
	logic [CB:0] need_tot;
	always_comb begin
		fits = (ew >= rw_q) && (eh >= rh_q) && (link != bsp_pkg::LinkFull);
		nw = rw_q < ew;
		nh = rh_q < eh;
		need_tot = {1'b0, count_q} + (CB+1)'(nw) + (CB+1)'(nh);
		room = need_tot <= (CB+1)'(bsp_pkg::MaxNodes);
	end

	logic leaf;
	assign leaf = link == bsp_pkg::LinkEmpty;
	assign sts.clear_done  = clr_q == CB'(bsp_pkg::MaxNodes - 1);
	assign sts.stack_empty = depth_q == '0;
	assign sts.drop        = {{(CB-IB){1'b0}}, ent_q.node} >= count_q;
	assign sts.finish      = fits && leaf;
	assign sts.no_room     = !room;
	assign sts.need1       = need_w_q;
	assign sts.need2       = need_h_q;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aw_q <= 13'd1024; ah_q <= 13'd1024;
			count_q <= CB'(1); depth_q <= '0; clr_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_sel == bsp_pkg::CfgWidth) aw_q <= cfg_val;
				else ah_q <= cfg_val;
			end
			// a register write restarts the clearing pass from node 0
			if (cfg_we || cmd.start) clr_q <= '0;
			else if (cmd.clear) clr_q <= clr_q + CB'(1);
			if (cmd.clear) count_q <= CB'(1);
			if (cmd.start) depth_q <= CB'(1);
			if (cmd.rd_node && sts.drop) depth_q <= depth_q - CB'(1);
			if (cmd.eval) begin
				if (side && !(fits && !leaf)) depth_q <= depth_q - CB'(1);
				else if (!side && fits && !leaf) depth_q <= depth_q + CB'(1);
				if (fits && leaf && room)
					count_q <= CB'(need_tot);
			end
		end
	end

	// Memories and payload registers
	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			node_mem[clr_q[IB-1:0]] <= '{bsp_pkg::SplitTb, ah_q,
				bsp_pkg::LinkEmpty, bsp_pkg::LinkEmpty};
		end
		if (cmd.start) begin
			stk_mem[0] <= '{13'd0, 13'd0, aw_q, ah_q, IB'(0), 1'b0};
			rw_q <= rw; rh_q <= rh;
		end
		if (cmd.rd_stack) ent_q <= stk_mem[depth_q[IB-1:0] - IB'(1)];
		if (cmd.rd_node) node_q <= node_mem[ent_q.node];
		if (cmd.eval) begin
			tn_q <= ent_q.node; side_q <= side;
			need_w_q <= nw; need_h_q <= nh;
			if (!side) stk_mem[depth_q[IB-1:0] - IB'(1)] <= '{ent_q.x, ent_q.y,
				ent_q.w, ent_q.h, ent_q.node, 1'b1};
			if (fits && !leaf) begin
				if (side) stk_mem[depth_q[IB-1:0] - IB'(1)] <=
					'{ex, ey, ew, eh, link[IB-1:0], 1'b0};
				else stk_mem[depth_q[IB-1:0]] <=
					'{ex, ey, ew, eh, link[IB-1:0], 1'b0};
			end
			// result only when an empty leaf fits
			if (fits && leaf) begin
				res_status <= room ? bsp_pkg::StPlaced : bsp_pkg::StFull;
				res_x <= room ? ex[11:0] : 12'd0;
				res_y <= room ? ey[11:0] : 12'd0;
			end
		end
		if (cmd.start) begin
			res_status <= bsp_pkg::StNoFit; res_x <= '0; res_y <= '0;
		end
		// insertion: write parent link, then new node(s)
		if (cmd.ins1) begin
			if (side_q) node_mem[tn_q].link_b <= need_w_q || need_h_q
				? 16'(count_q - CB'(32'(need_w_q) + 32'(need_h_q)))
				: bsp_pkg::LinkFull;
			else node_mem[tn_q].link_a <= need_w_q || need_h_q
				? 16'(count_q - CB'(32'(need_w_q) + 32'(need_h_q)))
				: bsp_pkg::LinkFull;
		end
		if (cmd.ins2) begin
			if (need_w_q) begin
				node_mem[IB'(count_q - CB'(32'(need_w_q) + 32'(need_h_q)))] <=
					'{bsp_pkg::SplitLr, rw_q,
					need_h_q ? 16'(count_q - CB'(1)) : bsp_pkg::LinkFull,
					bsp_pkg::LinkEmpty};
				if (need_h_q) node_mem[IB'(count_q - CB'(1))] <=
					'{bsp_pkg::SplitTb, rh_q, bsp_pkg::LinkFull, bsp_pkg::LinkEmpty};
			end else begin
				node_mem[IB'(count_q - CB'(1))] <=
					'{bsp_pkg::SplitTb, rh_q, bsp_pkg::LinkFull, bsp_pkg::LinkEmpty};
			end
		end
	end
endmodule
`default_nettype wire

// File: sv/bsp_ctrl.sv
// Controller state machine sequencing the tree walk.
`default_nettype none
module bsp_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_hit,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire bsp_pkg::sts_t sts,
	output bsp_pkg::cmd_t      cmd
);
	bsp_pkg::state_t state_q, state_d;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bsp_pkg::ST_IDLE:   if (in_valid) state_d = bsp_pkg::ST_START;
			bsp_pkg::ST_CLEAR:  if (sts.clear_done) state_d = bsp_pkg::ST_IDLE;
			bsp_pkg::ST_START:  state_d = bsp_pkg::ST_RDSTK;
			bsp_pkg::ST_RDSTK:  state_d = sts.stack_empty ? bsp_pkg::ST_DONE
			                                              : bsp_pkg::ST_RDNODE;
			bsp_pkg::ST_RDNODE: state_d = sts.drop ? bsp_pkg::ST_RDSTK : bsp_pkg::ST_EVAL;
			bsp_pkg::ST_EVAL: begin
				if (!sts.finish) state_d = bsp_pkg::ST_RDSTK;
				else if (sts.no_room) state_d = bsp_pkg::ST_DONE;
				else state_d = bsp_pkg::ST_INS1;
			end
			bsp_pkg::ST_INS1:   state_d = (sts.need1 || sts.need2) ? bsp_pkg::ST_INS2
			                                                       : bsp_pkg::ST_DONE;
			bsp_pkg::ST_INS2:   state_d = bsp_pkg::ST_DONE;
			bsp_pkg::ST_DONE:   if (out_ready) state_d = bsp_pkg::ST_IDLE;
			default:            state_d = bsp_pkg::ST_IDLE;
		endcase
		if (cfg_hit) state_d = bsp_pkg::ST_CLEAR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= bsp_pkg::ST_CLEAR;
		else state_q <= state_d;
	end

	// Outputs
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			bsp_pkg::ST_IDLE:   begin in_ready = 1'b1; cmd.start = in_valid; end
			bsp_pkg::ST_CLEAR:  cmd.clear = 1'b1;
			bsp_pkg::ST_START:  ;
			bsp_pkg::ST_RDSTK:  cmd.rd_stack = !sts.stack_empty;
			bsp_pkg::ST_RDNODE: cmd.rd_node = 1'b1;
			bsp_pkg::ST_EVAL:   cmd.eval = 1'b1;
			bsp_pkg::ST_INS1:   cmd.ins1 = 1'b1;
			bsp_pkg::ST_INS2:   cmd.ins2 = 1'b1;
			bsp_pkg::ST_DONE:   out_valid = 1'b1;
			default:            ;
		endcase
	end

`ifndef SYNTHESIS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid) else $error("ready while result pending");
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready && !cfg_hit) |=> out_valid)
		else $error("result dropped");
	a_ins_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.ins1 && (sts.need1 || sts.need2) && !cfg_hit) |=> cmd.ins2)
		else $error("insert split");
`endif
endmodule
`default_nettype wire

// File: sv/bsp_rectangle_packer_core.sv
// Top level of the binary-tree rectangle packer.
// Usage:
//  req channel carries req_width/req_height; res channel returns status,
//  pos_x, pos_y (status 0 placed, 1 no fit, 2 node store exhausted).
//  One request at a time. After the request transaction: a start state,
//  then a stack read, node read and evaluate for every side of a node
//  that is tried. A placement adds a link update, plus a node write when
//  new nodes are cut; an exhausted store adds neither; a walk with no fit
//  ends with a final stack check. The result is then valid, and the
//  block returns to idle after its transaction before the next request
//  is accepted.
//  The result waits in the output register until taken, so a stalled
//  receiver simply holds it; nothing is lost.
//  Reset and every configuration write rebuild the root and run a
//  clearing pass over all 1024 entries of the node memory; requests are held
//  off meanwhile. Write configuration only with no request in flight;
//  a write aborts a walk in progress.
//  cfg_we/cfg_index/cfg_data write atlas_width (0) or atlas_height (1).
`default_nettype none
module bsp_rectangle_packer_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [12:0] cfg_data,
	bsp_req_if.sink          req,
	bsp_res_if.source        res
);
	bsp_pkg::cmd_t cmd;
	bsp_pkg::sts_t sts;

	bsp_ctrl u_ctrl (
		.clk, .arst_n, .cfg_hit(cfg_we),
		.in_valid(req.valid), .in_ready(req.ready),
		.out_valid(res.valid), .out_ready(res.ready),
		.sts, .cmd
	);

	bsp_datapath u_dp (
		.clk, .arst_n, .cmd, .sts,
		.cfg_we, .cfg_sel(cfg_index[0]), .cfg_val(cfg_data),
		.rw(req.req_width), .rh(req.req_height),
		.res_status(res.status), .res_x(res.pos_x), .res_y(res.pos_y)
	);
endmodule
`default_nettype wire

// File: tb/sv/bsp_rectangle_packer_core_tb.sv
// Self-checking testbench for the binary-tree rectangle packer core.
`timescale 1ns / 1ps
`default_nettype none
module bsp_rectangle_packer_core_tb;

	localparam int IdleLimit = 200000;

	typedef struct {
		logic [1:0]  status;
		logic [11:0] pos_x;
		logic [11:0] pos_y;
	} placement_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [0:0] cfg_index;
	logic [12:0] cfg_data;

	bsp_req_if req_ch ();
	bsp_res_if res_ch ();

	bsp_rectangle_packer_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.res       (res_ch)
	);

	// predicted block state
	bsp_pkg::coord_t   atlas_w;
	bsp_pkg::coord_t   atlas_h;
	logic              tree_kind [bsp_pkg::MaxNodes];
	bsp_pkg::coord_t   tree_split [bsp_pkg::MaxNodes];
	logic [bsp_pkg::LinkBits-1:0] tree_link_a [bsp_pkg::MaxNodes];
	logic [bsp_pkg::LinkBits-1:0] tree_link_b [bsp_pkg::MaxNodes];
	int unsigned       tree_used;

	// walk stack of the predictor
	int unsigned       walk_x [bsp_pkg::MaxNodes];
	int unsigned       walk_y [bsp_pkg::MaxNodes];
	int unsigned       walk_w [bsp_pkg::MaxNodes];
	int unsigned       walk_h [bsp_pkg::MaxNodes];
	int unsigned       walk_node [bsp_pkg::MaxNodes];
	bit                walk_tried [bsp_pkg::MaxNodes];
	int unsigned       walk_top;

	placement_t        placement_q [$];
	int                errors;
	int                idle_cycles;
	bit                gaps_on;
	int                ready_hold;
	int                full_seen;

	// clock, 2 ns period
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic void clear_tree();
		tree_kind[0]   = bsp_pkg::SplitTb;
		tree_split[0]  = atlas_h;
		tree_link_a[0] = bsp_pkg::LinkEmpty;
		tree_link_b[0] = bsp_pkg::LinkEmpty;
		tree_used      = 1;
	endfunction

	function automatic int unsigned alloc_node(logic kind, int unsigned split);
		int unsigned idx;
		idx = tree_used;
		tree_kind[idx]   = kind;
		tree_split[idx]  = bsp_pkg::coord_t'(split);
		tree_link_a[idx] = bsp_pkg::LinkEmpty;
		tree_link_b[idx] = bsp_pkg::LinkEmpty;
		tree_used++;
		return idx;
	endfunction

	function automatic void walk_push(int unsigned x, int unsigned y, int unsigned w,
			int unsigned h, int unsigned node);
		if (walk_top >= bsp_pkg::MaxNodes)
			return;
		walk_x[walk_top]     = x & 32'h1FFF;
		walk_y[walk_top]     = y & 32'h1FFF;
		walk_w[walk_top]     = w & 32'h1FFF;
		walk_h[walk_top]     = h & 32'h1FFF;
		walk_node[walk_top]  = node;
		walk_tried[walk_top] = 1'b0;
		walk_top++;
	endfunction

	function automatic void set_link(int unsigned node, int side,
			logic [bsp_pkg::LinkBits-1:0] val);
		if (side == 0)
			tree_link_a[node] = val;
		else
			tree_link_b[node] = val;
	endfunction

	// depth-first search for the first empty leaf that fits, then cut it
	function automatic placement_t place_rect(bsp_pkg::coord_t rw, bsp_pkg::coord_t rh);
		placement_t  p;
		int unsigned ni, x, y, w, h, sp, need, tn, k;
		int          side, ts;
		logic [bsp_pkg::LinkBits-1:0] link;
		p.status = bsp_pkg::StNoFit;
		p.pos_x  = '0;
		p.pos_y  = '0;
		walk_top = 0;
		walk_push(0, 0, atlas_w, atlas_h, 0);
		while (walk_top > 0) begin
			ni = walk_node[walk_top-1];
			if (ni >= tree_used) begin
				walk_top--;
				continue;
			end
			x  = walk_x[walk_top-1];
			y  = walk_y[walk_top-1];
			w  = walk_w[walk_top-1];
			h  = walk_h[walk_top-1];
			sp = tree_split[ni];
			if (tree_kind[ni] == bsp_pkg::SplitTb) begin
				if (walk_tried[walk_top-1]) begin
					y += sp;
					h = (h >= sp) ? h - sp : 0;
				end else
					h = sp;
			end else begin
				if (walk_tried[walk_top-1]) begin
					x += sp;
					w = (w >= sp) ? w - sp : 0;
				end else
					w = sp;
			end
			if (walk_tried[walk_top-1]) begin
				side = 1;
				walk_top--;
			end else begin
				side = 0;
				walk_tried[walk_top-1] = 1'b1;
			end
			if (w < rw || h < rh)
				continue;
			link = (side == 0) ? tree_link_a[ni] : tree_link_b[ni];
			if (link == bsp_pkg::LinkFull)
				continue;
			if (link == bsp_pkg::LinkEmpty) begin
				need = (rw < w ? 1 : 0) + (rh < h ? 1 : 0);
				if (tree_used + need > bsp_pkg::MaxNodes) begin
					p.status = bsp_pkg::StFull;
					return p;
				end
				tn = ni;
				ts = side;
				if (rw < w) begin
					k = alloc_node(bsp_pkg::SplitLr, rw);
					set_link(tn, ts, bsp_pkg::LinkBits'(k));
					tn = k;
					ts = 0;
				end
				if (rh < h) begin
					k = alloc_node(bsp_pkg::SplitTb, rh);
					set_link(tn, ts, bsp_pkg::LinkBits'(k));
					tn = k;
					ts = 0;
				end
				set_link(tn, ts, bsp_pkg::LinkFull);
				p.status = bsp_pkg::StPlaced;
				p.pos_x  = x[11:0];
				p.pos_y  = y[11:0];
				return p;
			end
			walk_push(x, y, w, h, link);
		end
		return p;
	endfunction

	function automatic int pick_gap();
		int r;
		if (!gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 15);
		return $urandom_range(20, 100);
	endfunction

	task automatic report_mismatch(string field, int got, int want);
		$display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
		errors++;
	endtask

	// one request transaction; the expectation is recorded on acceptance
	task automatic send_request(bsp_pkg::coord_t rw, bsp_pkg::coord_t rh);
		int         gap;
		placement_t p;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.req_width  <= rw;
		req_ch.req_height <= rh;
		do
			@(posedge clk);
		while (!req_ch.ready);
		p = place_rect(rw, rh);
		if (p.status == bsp_pkg::StFull)
			full_seen++;
		placement_q.push_back(p);
	endtask

	task automatic drain();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		wait (placement_q.size() == 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [12:0] val);
		drain();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == bsp_pkg::CfgWidth)
			atlas_w = val;
		else
			atlas_h = val;
		clear_tree();
	endtask

	task automatic set_atlas(logic [12:0] w, logic [12:0] h);
		write_reg(bsp_pkg::CfgWidth, w);
		write_reg(bsp_pkg::CfgHeight, h);
	endtask

	// result checker
	always @(posedge clk) begin
		placement_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (placement_q.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				want = placement_q.pop_front();
				if (res_ch.status !== want.status)
					report_mismatch("status", res_ch.status, want.status);
				if (res_ch.pos_x !== want.pos_x)
					report_mismatch("pos_x", res_ch.pos_x, want.pos_x);
				if (res_ch.pos_y !== want.pos_y)
					report_mismatch("pos_y", res_ch.pos_y, want.pos_y);
			end
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		if (ready_hold > 0) begin
			res_ch.ready <= 1'b0;
			ready_hold--;
		end else begin
			res_ch.ready <= 1'b1;
			ready_hold = pick_gap();
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IdleLimit) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// default atlas straight after reset
	task automatic test_reset_state();
		send_request(13'd1024, 13'd1024);
		send_request(13'd1, 13'd1);
		send_request(13'd0, 13'd0);
	endtask

	// field extremes and zero sizes
	task automatic test_extremes();
		set_atlas(13'd4096, 13'd4096);
		send_request(13'd0, 13'd0);
		send_request(13'd4096, 13'd1);
		send_request(13'd1, 13'd4096);
		send_request(13'd8191, 13'd1);
		send_request(13'd1, 13'd8191);
		send_request(13'd4095, 13'd4095);
		send_request(13'd2048, 13'd2048);
		send_request(13'd2048, 13'd2048);
		send_request(13'd0, 13'd4096);
		send_request(13'd4096, 13'd0);
		set_atlas(13'd8191, 13'd8191);
		send_request(13'd8191, 13'd8191);
		send_request(13'd4096, 13'd4096);
		set_atlas(13'd1, 13'd1);
		send_request(13'd1, 13'd1);
		send_request(13'd1, 13'd1);
		send_request(13'd0, 13'd0);
		set_atlas(13'd0, 13'd0);
		send_request(13'd0, 13'd0);
		send_request(13'd1, 13'd0);
		write_reg(bsp_pkg::CfgWidth, 13'd4096);
		send_request(13'd100, 13'd0);
	endtask

	// tall one-wide columns cost two nodes each until the store runs out
	task automatic test_store_full();
		int n;
		set_atlas(13'd4096, 13'd4096);
		n = 0;
		while (full_seen < 4 && n < 600) begin
			send_request(13'd1, 13'd3000);
			n++;
		end
		send_request(13'd4096, 13'd4096);
	endtask

	function automatic bsp_pkg::coord_t rand_size(bsp_pkg::coord_t lim);
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return bsp_pkg::coord_t'($urandom_range(0, (lim > 4) ? lim / 4 : 1));
		if (r < 85)
			return bsp_pkg::coord_t'($urandom_range(0, lim));
		if (r < 93)
			case ($urandom_range(0, 4))
				0: return 13'd0;
				1: return 13'd1;
				2: return 13'd4096;
				3: return 13'd8191;
				default: return lim;
			endcase
		return bsp_pkg::coord_t'($urandom);
	endfunction

	function automatic logic [12:0] rand_atlas();
		case ($urandom_range(0, 5))
			0: return 13'd1;
			1: return 13'd4096;
			2: return 13'($urandom_range(16, 256));
			3: return 13'($urandom);
			default: return 13'($urandom_range(1, 4096));
		endcase
	endfunction

	// random requests over a series of atlas settings
	task automatic test_random(int count);
		int left, seg;
		left = count;
		while (left > 0) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 1))
				set_atlas(rand_atlas(), rand_atlas());
			else
				write_reg(1'($urandom_range(0, 1)), rand_atlas());
			seg = $urandom_range(10, 60);
			repeat (seg) begin
				send_request(rand_size(atlas_w), rand_size(atlas_h));
				left--;
			end
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = bsp_pkg::CfgWidth;
		cfg_data          = '0;
		req_ch.valid      = 1'b0;
		req_ch.req_width  = '0;
		req_ch.req_height = '0;
		res_ch.ready      = 1'b0;
		errors            = 0;
		idle_cycles       = 0;
		ready_hold        = 0;
		full_seen         = 0;
		gaps_on           = 1'b1;
		atlas_w           = 13'd1024;
		atlas_h           = 13'd1024;
		clear_tree();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_extremes();
		test_store_full();
		test_random(360);

		drain();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
`default_nettype wire

// File: filelist.f
sv/bsp_pkg.sv
sv/bsp_if.sv
sv/bsp_datapath.sv
sv/bsp_ctrl.sv
sv/bsp_rectangle_packer_core.sv
tb/sv/bsp_rectangle_packer_core_tb.sv
